>>> hdl/yc2rgb_pkg.sv
// ----------------------------------------------------------------------------
// yc2rgb_pkg
// Shared widths, register indexes, format codes and coefficients for the
// YCbCr to packed RGB converter.
// ----------------------------------------------------------------------------
package yc2rgb_pkg;

  // Configuration port
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;

  localparam logic [CfgIndexWidth-1:0] REG_OUTPUT_FORMAT  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_LSB_FIRST      = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_RED_POSITION   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_GREEN_POSITION = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_BLUE_POSITION  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_RED_BITS       = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_GREEN_BITS     = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_BLUE_BITS      = 3'd7;

  // Output format codes
  localparam logic [1:0] FMT_PACKED16 = 2'd0;
  localparam logic [1:0] FMT_BYTES3   = 2'd1;
  localparam logic [1:0] FMT_BYTES4   = 2'd2;

  // Register reset values
  localparam logic [1:0] RST_OUTPUT_FORMAT  = FMT_PACKED16;
  localparam logic       RST_LSB_FIRST      = 1'b1;
  localparam logic [4:0] RST_RED_POSITION   = 5'd11;
  localparam logic [4:0] RST_GREEN_POSITION = 5'd5;
  localparam logic [4:0] RST_BLUE_POSITION  = 5'd0;
  localparam logic [3:0] RST_RED_BITS       = 4'd5;
  localparam logic [3:0] RST_GREEN_BITS     = 4'd6;
  localparam logic [3:0] RST_BLUE_BITS      = 4'd5;

  // Signed width of the channel sums
  localparam int SumWidth = 19;

  // BT.601 coefficients scaled by 256, and sample offsets
  localparam logic signed [SumWidth-1:0] CoefLuma = 19'sd298;
  localparam logic signed [SumWidth-1:0] CoefRv   = 19'sd409;
  localparam logic signed [SumWidth-1:0] CoefGu   = 19'sd100;
  localparam logic signed [SumWidth-1:0] CoefGv   = 19'sd208;
  localparam logic signed [SumWidth-1:0] CoefBu   = 19'sd516;
  localparam logic signed [8:0]          LumaOffset   = 9'sd16;
  localparam logic signed [8:0]          ChromaOffset = 9'sd128;

  // Clipping limits
  localparam logic signed [SumWidth-1:0] Sat16Limit = 19'sh0ff00;
  localparam logic [7:0]                 ByteMax    = 8'd255;

  // Byte counts
  localparam logic [2:0] COUNT_2 = 3'd2;
  localparam logic [2:0] COUNT_3 = 3'd3;
  localparam logic [2:0] COUNT_4 = 3'd4;

endpackage

>>> hdl/yc2rgb_pixel_if.sv
// ----------------------------------------------------------------------------
// yc2rgb_pixel_if
// Valid/ready channel carrying one YCbCr pixel.
// ----------------------------------------------------------------------------
interface yc2rgb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] blue_diff;
  logic [7:0] red_diff;

  modport source (output valid, output luma, output blue_diff, output red_diff,
                  input ready);
  modport sink   (input valid, input luma, input blue_diff, input red_diff,
                  output ready);
endinterface

>>> hdl/yc2rgb_packed_if.sv
// ----------------------------------------------------------------------------
// yc2rgb_packed_if
// Valid/ready channel carrying one packed RGB pixel in memory byte order.
// ----------------------------------------------------------------------------
interface yc2rgb_packed_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_bytes;
  logic [2:0]  byte_count;
  logic        layout_error;

  modport source (output valid, output pixel_bytes, output byte_count,
                  output layout_error, input ready);
  modport sink   (input valid, input pixel_bytes, input byte_count,
                  input layout_error, output ready);
endinterface

>>> hdl/yc2rgb_cfg_if.sv
// ----------------------------------------------------------------------------
// yc2rgb_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface yc2rgb_cfg_if
  import yc2rgb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ycbcr_to_packed_rgb_converter.sv
// ----------------------------------------------------------------------------
// ycbcr_to_packed_rgb_converter
// BT.601 integer YCbCr to RGB conversion, packed into a 16-bit masked word or
// a three or four byte pixel in memory byte order.
// ----------------------------------------------------------------------------
//
//   channel    dir  transfer when      payload
//   pixel_in   in   valid && ready     luma, blue_diff, red_diff
//   pixel_out  out  valid && ready     pixel_bytes, byte_count, layout_error
//   cfg        in   valid && ready     index, data (ready is always high)
//
// One pixel per clock sustained while the output is not stalled; each pixel
// passes through the product, sum, channel field and packing register stages.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the output register waits.
// Reset clears the valid bits and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module ycbcr_to_packed_rgb_converter
  import yc2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  yc2rgb_pixel_if.sink     pixel_in,
  yc2rgb_packed_if.source  pixel_out,
  yc2rgb_cfg_if.sink       cfg
);

  // Configuration registers
  logic [1:0] output_format;
  logic       lsb_first;
  logic [4:0] position [3];
  logic [3:0] bits     [3];

  assign cfg.ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      output_format <= RST_OUTPUT_FORMAT;
      lsb_first     <= RST_LSB_FIRST;
      position[0]   <= RST_RED_POSITION;
      position[1]   <= RST_GREEN_POSITION;
      position[2]   <= RST_BLUE_POSITION;
      bits[0]       <= RST_RED_BITS;
      bits[1]       <= RST_GREEN_BITS;
      bits[2]       <= RST_BLUE_BITS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OUTPUT_FORMAT:  output_format <= cfg.data[1:0];
        REG_LSB_FIRST:      lsb_first     <= cfg.data[0];
        REG_RED_POSITION:   position[0]   <= cfg.data[4:0];
        REG_GREEN_POSITION: position[1]   <= cfg.data[4:0];
        REG_BLUE_POSITION:  position[2]   <= cfg.data[4:0];
        REG_RED_BITS:       bits[0]       <= cfg.data[3:0];
        REG_GREEN_BITS:     bits[1]       <= cfg.data[3:0];
        REG_BLUE_BITS:      bits[2]       <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves
  logic s1_valid, s2_valid, s3_valid;
  logic out_en, s3_en, s2_en, s1_en;

  assign out_en = !pixel_out.valid || pixel_out.ready;
  assign s3_en  = !s3_valid || out_en;
  assign s2_en  = !s2_valid || s3_en;
  assign s1_en  = !s1_valid || s2_en;
  assign pixel_in.ready = s1_en;

  // Stage 1: remove offsets and form the coefficient products
  logic signed [8:0] y_off, cb_off, cr_off;
  logic signed [SumWidth-1:0] prod_luma, prod_rv, prod_gu, prod_gv, prod_bu;

  assign y_off  = $signed({1'b0, pixel_in.luma})      - LumaOffset;
  assign cb_off = $signed({1'b0, pixel_in.blue_diff}) - ChromaOffset;
  assign cr_off = $signed({1'b0, pixel_in.red_diff})  - ChromaOffset;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && pixel_in.valid) begin
      prod_luma <= SumWidth'(y_off)  * CoefLuma;
      prod_rv   <= SumWidth'(cr_off) * CoefRv;
      prod_gu   <= SumWidth'(cb_off) * CoefGu;
      prod_gv   <= SumWidth'(cr_off) * CoefGv;
      prod_bu   <= SumWidth'(cb_off) * CoefBu;
    end
  end

  // Stage 2: channel sums (red, green, blue)
  logic signed [SumWidth-1:0] sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      sum[0] <= prod_luma + prod_rv;
      sum[1] <= prod_luma - prod_gu - prod_gv;
      sum[2] <= prod_luma + prod_bu;
    end
  end

  // Stage 3: per-channel masked 16-bit field and clipped byte
  function automatic logic [15:0] field16(logic signed [SumWidth-1:0] s,
                                          logic [3:0] nbits, logic [4:0] pos);
    logic [16:0] ones;
    logic [15:0] mask;
    logic [5:0]  shift;
    ones  = (17'd1 << nbits) - 17'd1;
    mask  = ones[15:0] << pos;
    shift = 6'd16 - 6'(nbits) - 6'(pos);
    if (s <= 0) begin
      field16 = '0;
    end else if (s > Sat16Limit) begin
      field16 = mask;
    end else begin
      field16 = (s[15:0] >> shift) & mask;
    end
  endfunction

  function automatic logic [7:0] clip8(logic signed [SumWidth-1:0] s);
    if (s < 0) begin
      clip8 = '0;
    end else if (s[SumWidth-2:8] > (SumWidth-9)'(ByteMax)) begin
      clip8 = ByteMax;
    end else begin
      clip8 = s[15:8];
    end
  endfunction

  logic [15:0] chan_field [3];
  logic [7:0]  chan_byte  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) begin
      for (int k = 0; k < 3; k++) begin
        chan_field[k] <= field16(sum[k], bits[k], position[k]);
        chan_byte[k]  <= clip8(sum[k]);
      end
    end
  end

  // Stage 4: check layout and pack into memory byte order
  logic [31:0] pix_next;
  logic [2:0]  count_next;
  logic        err_next;

  always_comb begin
    logic [15:0] word;
    logic [1:0]  lane;
    logic [1:0]  idx;
    logic [1:0]  last_idx;
    pix_next   = '0;
    count_next = COUNT_4;
    err_next   = 1'b0;
    word       = '0;
    lane       = '0;
    idx        = '0;
    last_idx   = '0;
    case (output_format)
      FMT_PACKED16: begin
        count_next = COUNT_2;
        for (int k = 0; k < 3; k++) begin
          if (6'(bits[k]) + 6'(position[k]) > 6'd16) err_next = 1'b1;
          word = word | chan_field[k];
        end
        pix_next = lsb_first ? {16'd0, word} : {16'd0, word[7:0], word[15:8]};
      end
      FMT_BYTES3, FMT_BYTES4: begin
        count_next = (output_format == FMT_BYTES3) ? COUNT_3 : COUNT_4;
        last_idx   = 2'(count_next - 3'd1);
        for (int k = 0; k < 3; k++) begin
          lane = position[k][4:3];
          if (bits[k] != 4'd8 || position[k][2:0] != 3'd0 ||
              3'(lane) >= count_next) begin
            err_next = 1'b1;
          end
          idx = lsb_first ? lane : (last_idx - lane);
          case (idx)
            2'd0:    pix_next[7:0]   = chan_byte[k];
            2'd1:    pix_next[15:8]  = chan_byte[k];
            2'd2:    pix_next[23:16] = chan_byte[k];
            default: pix_next[31:24] = chan_byte[k];
          endcase
        end
      end
      default: begin
        count_next = COUNT_4;
        err_next   = 1'b1;
      end
    endcase
    if (err_next) pix_next = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_out.valid <= 1'b0;
    end else if (out_en) begin
      pixel_out.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s3_valid) begin
      pixel_out.pixel_bytes  <= pix_next;
      pixel_out.byte_count   <= count_next;
      pixel_out.layout_error <= err_next;
    end
  end

endmodule

>>> bench/yc2rgb_result_checker.sv
// ----------------------------------------------------------------------------
// yc2rgb_result_checker
// Watches the pixel, packed pixel and register channels of the converter,
// works out the packed pixel that each accepted YCbCr pixel must give under
// the current register settings, and compares every packed result, field by
// field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module yc2rgb_result_checker
  import yc2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  yc2rgb_pixel_if  pixel_in,
  yc2rgb_packed_if pixel_out,
  yc2rgb_cfg_if    cfg,
  output int       mismatches,
  output int       outstanding,
  output int       results_checked,
  output int       flagged_results
);

  localparam int PrintLimit = 25;

  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;
    logic        layout_error;
  } packed_result_t;

  // Shadow copy of the register file
  logic [1:0] format_q;
  logic       little_q;
  logic [4:0] pos_q [3];   // red, green, blue
  logic [3:0] width_q [3]; // red, green, blue

  packed_result_t expected_pixels [$];

  // Convert one pixel with BT.601 integer coefficients and pack it
  function automatic packed_result_t pack_pixel(input logic [7:0] y, input logic [7:0] cb,
                                                input logic [7:0] cr);
    int             luma_term;
    int             sum [3];
    int             lanes;
    int             slot;
    int             k;
    logic [31:0]    word;
    logic [31:0]    mask;
    logic [31:0]    field;
    logic [7:0]     level;
    packed_result_t res;
    luma_term = 298 * (int'(y) - 16);
    sum[0] = luma_term + 409 * (int'(cr) - 128);
    sum[1] = luma_term - 100 * (int'(cb) - 128) - 208 * (int'(cr) - 128);
    sum[2] = luma_term + 516 * (int'(cb) - 128);
    word = '0;
    res.layout_error = 1'b0;
    case (format_q)
      FMT_PACKED16: begin
        res.byte_count = COUNT_2;
        for (k = 0; k < 3; k++)
          if (int'(width_q[k]) + int'(pos_q[k]) > 16) res.layout_error = 1'b1;
        if (!res.layout_error) begin
          // Saturate at both ends, otherwise take the top bits into the mask
          for (k = 0; k < 3; k++) begin
            mask = ((32'd1 << width_q[k]) - 32'd1) << pos_q[k];
            if (sum[k] <= 0) field = '0;
            else if (sum[k] > Sat16Limit) field = mask;
            else field = (32'(sum[k]) >> (16 - int'(width_q[k]) - int'(pos_q[k]))) & mask;
            word |= field;
          end
          word = little_q ? {16'h0, word[15:0]} : {16'h0, word[7:0], word[15:8]};
        end
      end
      FMT_BYTES3, FMT_BYTES4: begin
        res.byte_count = (format_q == FMT_BYTES3) ? COUNT_3 : COUNT_4;
        lanes = int'(res.byte_count);
        for (k = 0; k < 3; k++)
          if (width_q[k] != 4'd8 || pos_q[k][2:0] != 3'd0 || int'(pos_q[k][4:3]) >= lanes)
            res.layout_error = 1'b1;
        if (!res.layout_error) begin
          // Later channels overwrite earlier ones on a shared lane
          for (k = 0; k < 3; k++) begin
            if (sum[k] < 0) level = '0;
            else if ((sum[k] >>> 8) > int'(ByteMax)) level = ByteMax;
            else level = 8'(sum[k] >>> 8);
            slot = little_q ? int'(pos_q[k][4:3]) : lanes - 1 - int'(pos_q[k][4:3]);
            word[slot*8 +: 8] = level;
          end
        end
      end
      default: begin
        res.byte_count   = COUNT_4;
        res.layout_error = 1'b1;
      end
    endcase
    res.pixel_bytes = res.layout_error ? '0 : word;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("mismatch at result %0d: %s got %h, expected %h",
               results_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    packed_result_t want;
    if (rst) begin
      format_q        = RST_OUTPUT_FORMAT;
      little_q        = RST_LSB_FIRST;
      pos_q[0]        = RST_RED_POSITION;
      pos_q[1]        = RST_GREEN_POSITION;
      pos_q[2]        = RST_BLUE_POSITION;
      width_q[0]      = RST_RED_BITS;
      width_q[1]      = RST_GREEN_BITS;
      width_q[2]      = RST_BLUE_BITS;
      mismatches      = 0;
      results_checked = 0;
      flagged_results = 0;
      expected_pixels.delete();
    end else begin
      // Track register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_OUTPUT_FORMAT:  format_q   = cfg.data[1:0];
          REG_LSB_FIRST:      little_q   = cfg.data[0];
          REG_RED_POSITION:   pos_q[0]   = cfg.data[4:0];
          REG_GREEN_POSITION: pos_q[1]   = cfg.data[4:0];
          REG_BLUE_POSITION:  pos_q[2]   = cfg.data[4:0];
          REG_RED_BITS:       width_q[0] = cfg.data[3:0];
          REG_GREEN_BITS:     width_q[1] = cfg.data[3:0];
          REG_BLUE_BITS:      width_q[2] = cfg.data[3:0];
          default: ;
        endcase
      end
      // Queue the expected packing of each input transfer
      if (pixel_in.valid && pixel_in.ready)
        expected_pixels.push_back(pack_pixel(pixel_in.luma, pixel_in.blue_diff,
                                             pixel_in.red_diff));
      // Compare each output transfer with the oldest expectation
      if (pixel_out.valid && pixel_out.ready) begin
        results_checked++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result, pixel_bytes", pixel_out.pixel_bytes, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (want.layout_error) flagged_results++;
          if (pixel_out.pixel_bytes !== want.pixel_bytes)
            report_mismatch("pixel_bytes", pixel_out.pixel_bytes, want.pixel_bytes);
          if (pixel_out.byte_count !== want.byte_count)
            report_mismatch("byte_count", 32'(pixel_out.byte_count), 32'(want.byte_count));
          if (pixel_out.layout_error !== want.layout_error)
            report_mismatch("layout_error", 32'(pixel_out.layout_error),
                            32'(want.layout_error));
        end
      end
    end
    outstanding <= expected_pixels.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the YCbCr to packed RGB converter: a directed
// sweep of sample extremes and special field layouts, then random pixels
// under random register settings, with random gaps on both channels, a long
// output stall and pauses that drain the pipeline.
// ----------------------------------------------------------------------------
module tb
  import yc2rgb_pkg::*;
;

  localparam int         ClkPeriod     = 20;
  localparam int         ItemCount     = 1900;
  localparam int         IdlePct       = 23;
  localparam int         HoldCycles    = 64;
  localparam int         SettleCycles  = 10;
  localparam int         TimeoutCycles = 300000;
  localparam logic [1:0] FMT_RESERVED  = 2'd3;

  logic clk = 1'b0;
  logic rst;

  yc2rgb_pixel_if  pixel_in ();
  yc2rgb_packed_if pixel_out ();
  yc2rgb_cfg_if    cfg ();

  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   flagged_results;
  int   pixels_sent   = 0;
  int   settings_used = 1;
  int   idle_pct      = IdlePct;
  logic hold_request  = 1'b0;
  logic pad_upper     = 1'b0;

  // Directed samples {luma, blue_diff, red_diff}: corners, black, white, grays
  logic [23:0] directed_pixels [13] = '{
    24'h000000, 24'h0000ff, 24'h00ff00, 24'h00ffff,
    24'hff0000, 24'hff00ff, 24'hffff00, 24'hffffff,
    24'h108080, 24'heb8080, 24'hff8080, 24'h008080, 24'h118080
  };

  ycbcr_to_packed_rgb_converter dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .pixel_out (pixel_out),
    .cfg       (cfg)
  );

  yc2rgb_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .pixel_in        (pixel_in),
    .pixel_out       (pixel_out),
    .cfg             (cfg),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .flagged_results (flagged_results)
  );

  always begin
    #(ClkPeriod / 2) clk = 1'b1;
    #(ClkPeriod / 2) clk = 1'b0;
  end

  // Offer one pixel after a random gap and hold it until the transfer
  task automatic push_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
    while ($urandom_range(0, 99) < idle_pct) begin
      pixel_in.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_in.valid     <= 1'b1;
    pixel_in.luma      <= y;
    pixel_in.blue_diff <= cb;
    pixel_in.red_diff  <= cr;
    @(posedge clk);
    while (!pixel_in.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Stop offering and wait until every queued pixel has come out
  task automatic wait_drained();
    pixel_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Leave valid high so back-to-back writes need no extra assignment
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] value,
                           input int width);
    logic [7:0] fill;
    fill = pad_upper ? 8'($urandom) : 8'h00;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value | (fill << width);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic apply_layout(input logic [1:0] fmt, input logic le,
                              input logic [4:0] rp, input logic [4:0] gp, input logic [4:0] bp,
                              input logic [3:0] rb, input logic [3:0] gb, input logic [3:0] bb);
    pad_upper = ($urandom_range(0, 3) == 0);
    write_reg(REG_OUTPUT_FORMAT,  8'(fmt), 2);
    write_reg(REG_LSB_FIRST,      8'(le), 1);
    write_reg(REG_RED_POSITION,   8'(rp), 5);
    write_reg(REG_GREEN_POSITION, 8'(gp), 5);
    write_reg(REG_BLUE_POSITION,  8'(bp), 5);
    write_reg(REG_RED_BITS,       8'(rb), 4);
    write_reg(REG_GREEN_BITS,     8'(gb), 4);
    write_reg(REG_BLUE_BITS,      8'(bb), 4);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  // Drain, switch layout, and send one colorful pixel through it
  task automatic probe_layout(input logic [1:0] fmt, input logic le,
                              input logic [4:0] rp, input logic [4:0] gp, input logic [4:0] bp,
                              input logic [3:0] rb, input logic [3:0] gb, input logic [3:0] bb);
    wait_drained();
    apply_layout(fmt, le, rp, gp, bp, rb, gb, bb);
    push_pixel(8'd200, 8'd90, 8'd170);
  endtask

  // Mostly well-formed layouts for the chosen format, some arbitrary ones
  task automatic pick_layout();
    logic [1:0] fmt;
    logic       le;
    logic [4:0] p [3];
    logic [3:0] w [3];
    int         roll;
    int         lanes;
    int         k;
    roll = $urandom_range(0, 99);
    if (roll < 40) fmt = FMT_PACKED16;
    else if (roll < 65) fmt = FMT_BYTES3;
    else if (roll < 93) fmt = FMT_BYTES4;
    else fmt = FMT_RESERVED;
    le    = 1'($urandom_range(0, 1));
    lanes = (fmt == FMT_BYTES3) ? 3 : 4;
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 99) < 85 && fmt != FMT_RESERVED) begin
        if (fmt == FMT_PACKED16) begin
          w[k] = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
          p[k] = 5'($urandom_range(0, 16 - int'(w[k])));
        end else begin
          w[k] = 4'd8;
          p[k] = 5'(8 * $urandom_range(0, lanes - 1));
        end
      end else begin
        w[k] = 4'($urandom_range(0, 15));
        p[k] = 5'($urandom_range(0, 31));
      end
    end
    apply_layout(fmt, le, p[0], p[1], p[2], w[0], w[1], w[2]);
  endtask

  // Uniform sample most of the time, a range extreme or the midpoint otherwise
  function automatic logic [7:0] pick_sample();
    if ($urandom_range(0, 4) != 0) return 8'($urandom);
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd16;
      2:       return 8'd128;
      3:       return 8'd235;
      default: return 8'd255;
    endcase
  endfunction

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int held;
    logic hold_served;
    hold_served = 1'b0;
    pixel_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        pixel_out.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk);
      end
      pixel_out.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin
    int phase;
    int count;
    int i;
    rst                <= 1'b1;
    pixel_in.valid     <= 1'b0;
    pixel_in.luma      <= '0;
    pixel_in.blue_diff <= '0;
    pixel_in.red_diff  <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= '0;
    cfg.data           <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample extremes under the reset layout (565, little endian)
    foreach (directed_pixels[n])
      push_pixel(directed_pixels[n][23:16], directed_pixels[n][15:8], directed_pixels[n][7:0]);

    // Special layouts: byte order, empty and full-width fields, alpha lane,
    // shared lanes, every kind of bad layout and the reserved format
    probe_layout(FMT_PACKED16, 1'b0, 5'd11, 5'd5,  5'd0,  4'd5,  4'd6, 4'd5);
    probe_layout(FMT_PACKED16, 1'b1, 5'd8,  5'd0,  5'd0,  4'd8,  4'd8, 4'd0);
    probe_layout(FMT_PACKED16, 1'b1, 5'd1,  5'd0,  5'd31, 4'd15, 4'd1, 4'd1);
    probe_layout(FMT_PACKED16, 1'b0, 5'd0,  5'd0,  5'd0,  4'd15, 4'd15, 4'd15);
    probe_layout(FMT_BYTES3,   1'b1, 5'd16, 5'd8,  5'd0,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES3,   1'b0, 5'd16, 5'd8,  5'd0,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES4,   1'b1, 5'd16, 5'd8,  5'd0,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES4,   1'b0, 5'd24, 5'd16, 5'd8,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES4,   1'b1, 5'd0,  5'd0,  5'd8,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES3,   1'b1, 5'd24, 5'd8,  5'd0,  4'd8,  4'd8, 4'd8);
    probe_layout(FMT_BYTES4,   1'b0, 5'd16, 5'd8,  5'd4,  4'd8,  4'd7, 4'd8);
    probe_layout(FMT_RESERVED, 1'b1, 5'd11, 5'd5,  5'd0,  4'd5,  4'd6, 4'd5);

    // Random pixels under random layouts
    phase = 0;
    while (pixels_sent < ItemCount) begin
      phase++;
      wait_drained();
      pick_layout();
      idle_pct <= (phase == 6) ? 0 : IdlePct;
      if (phase == 3) hold_request <= 1'b1;
      count = (phase == 6) ? 300 : $urandom_range(30, 110);
      for (i = 0; i < count; i++) begin
        // Pause mid-phase until the pipeline is empty
        if (phase == 4 && i == count / 2) wait_drained();
        push_pixel(pick_sample(), pick_sample(), pick_sample());
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("converted %0d pixels under %0d register settings, all formats and byte orders",
             pixels_sent, settings_used);
    $display("%0d of %0d results carried the layout error flag",
             flagged_results, results_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d results outstanding", outstanding);
    $display("FAIL");
    $finish;
  end

endmodule
